@@ rtl/btpc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared widths, limits and register indexes of the barometer
// temperature and pressure compensation unit.
// ----------------------------------------------------------------------------
package btpc_pkg;

    localparam int RAW_WIDTH = 24;
    localparam int RAW_PORT_W = 24;
    localparam int COEF_W = 16;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_STG = 9;

    localparam int DT_W   = 25;
    localparam int PM_W   = 42;
    localparam int PD_W   = 50;
    localparam int T1D_W  = 18;
    localparam int T_W    = 20;
    localparam int T5_W   = 21;
    localparam int FA_W   = 39;
    localparam int OFF_W  = 37;
    localparam int SENS_W = 36;
    localparam int SLO_W  = 18;
    localparam int PPL_W  = 42;
    localparam int PPH_W  = 43;
    localparam int PRD_W  = 61;
    localparam int Q_W    = 41;
    localparam int P_W    = 26;
    localparam int TO_W   = 15;
    localparam int PO_W   = 17;

    localparam logic [RAW_PORT_W-1:0] RAW_MASK = RAW_PORT_W'((64'd1 << RAW_WIDTH) - 64'd1);

    localparam logic signed [T_W-1:0] TEMP_BASE = 20'sd2000;
    localparam logic signed [T_W-1:0] TEMP_MIN  = -20'sd4000;
    localparam logic signed [T_W-1:0] TEMP_MAX  = 20'sd8500;
    localparam logic signed [P_W-1:0] PRES_MIN  = 26'sd1000;
    localparam logic signed [P_W-1:0] PRES_MAX  = 26'sd120000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SENS       = 3'd0,
        CFG_OFFSET     = 3'd1,
        CFG_SENS_TEMP  = 3'd2,
        CFG_OFFSET_TMP = 3'd3,
        CFG_REF_TEMP   = 3'd4,
        CFG_TEMP_SLOPE = 3'd5
    } t_cfg_idx;

endpackage

@@ rtl/baro_temp_pressure_compensation_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit
// First- and second-order compensation of raw barometer conversions.
// ----------------------------------------------------------------------------
// Takes one raw temperature / raw pressure pair per beat and returns one
// compensated temperature (0.01 degC) and pressure (Pa) per beat, both
// saturated to the sensor range. The datapath is a nine-stage pipeline: it
// accepts a new beat every cycle while the output is taken. The stage count
// is set by the multiplier chain: the three first-order products with the
// square of dT, the square of the temperature error, and the pressure product
// split into two partial products and summed in the following stage. A stage
// holds only when it is full and the stage behind it cannot take its data, so
// a stalled output still lets empty stages fill. The six calibration words
// are written through the configuration channel, which is always ready;
// indexes above five are dropped.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [btpc_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [btpc_pkg::COEF_W-1:0]             i_cfg_data,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [btpc_pkg::RAW_PORT_W-1:0]         i_raw_temperature,
    input  logic [btpc_pkg::RAW_PORT_W-1:0]         i_raw_pressure,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [btpc_pkg::TO_W-1:0]        o_temperature_centi,
    output logic [btpc_pkg::PO_W-1:0]               o_pressure_pa,
    output logic                                    o_low_temp_applied,
    output logic                                    o_clamped
);

    localparam int NS = btpc_pkg::NUM_STG;

    // calibration words
    logic [btpc_pkg::COEF_W-1:0] r_c1, r_c2, r_c3, r_c4, r_c5, r_c6;

    // stage control
    logic [NS:1] r_vld;
    logic [NS:1] w_adv;

    // stage 1
    logic signed [btpc_pkg::DT_W-1:0]      r_s1_dt;
    logic [btpc_pkg::RAW_PORT_W-1:0]       r_s1_d1;
    // stage 2
    logic signed [btpc_pkg::PM_W-1:0]      r_s2_p6, r_s2_p4, r_s2_p3;
    logic signed [btpc_pkg::PD_W-1:0]      r_s2_pdd;
    logic [btpc_pkg::RAW_PORT_W-1:0]       r_s2_d1;
    // stage 3
    logic signed [btpc_pkg::T1D_W-1:0]     r_s3_t1d;
    logic signed [btpc_pkg::T5_W-1:0]      r_s3_t1d5;
    logic signed [btpc_pkg::T_W-1:0]       r_s3_t1;
    logic [btpc_pkg::T1D_W-1:0]            r_s3_dd;
    logic signed [btpc_pkg::OFF_W-1:0]     r_s3_off;
    logic signed [btpc_pkg::SENS_W-1:0]    r_s3_sens;
    logic                                  r_s3_low;
    logic [btpc_pkg::RAW_PORT_W-1:0]       r_s3_d1;
    // stage 4
    logic signed [btpc_pkg::FA_W-1:0]      r_s4_fa;
    logic signed [btpc_pkg::T_W-1:0]       r_s4_t1;
    logic [btpc_pkg::T1D_W-1:0]            r_s4_dd;
    logic signed [btpc_pkg::OFF_W-1:0]     r_s4_off;
    logic signed [btpc_pkg::SENS_W-1:0]    r_s4_sens;
    logic                                  r_s4_low;
    logic [btpc_pkg::RAW_PORT_W-1:0]       r_s4_d1;
    // stage 5
    logic signed [btpc_pkg::T_W-1:0]       r_s5_t;
    logic signed [btpc_pkg::OFF_W-1:0]     r_s5_off;
    logic signed [btpc_pkg::SENS_W-1:0]    r_s5_sens;
    logic                                  r_s5_low;
    logic [btpc_pkg::RAW_PORT_W-1:0]       r_s5_d1;
    // stage 6
    logic [btpc_pkg::PPL_W-1:0]            r_s6_ppl;
    logic signed [btpc_pkg::PPH_W-1:0]     r_s6_pph;
    logic signed [btpc_pkg::OFF_W-1:0]     r_s6_off;
    logic signed [btpc_pkg::T_W-1:0]       r_s6_t;
    logic                                  r_s6_tsat;
    logic                                  r_s6_low;
    // stage 7
    logic signed [btpc_pkg::PRD_W-1:0]     r_s7_prd;
    logic signed [btpc_pkg::OFF_W-1:0]     r_s7_off;
    logic signed [btpc_pkg::T_W-1:0]       r_s7_t;
    logic                                  r_s7_tsat;
    logic                                  r_s7_low;
    // stage 8
    logic signed [btpc_pkg::Q_W-1:0]       r_s8_q;
    logic signed [btpc_pkg::T_W-1:0]       r_s8_t;
    logic                                  r_s8_tsat;
    logic                                  r_s8_low;
    // stage 9 (output)
    logic signed [btpc_pkg::TO_W-1:0]      r_s9_t;
    logic [btpc_pkg::PO_W-1:0]             r_s9_p;
    logic                                  r_s9_low;
    logic                                  r_s9_sat;

    // next-value terms
    logic [btpc_pkg::RAW_PORT_W-1:0]       n_s1_d2, n_s1_d1;
    logic signed [btpc_pkg::DT_W-1:0]      n_s1_dt;
    logic signed [btpc_pkg::PM_W-1:0]      n_s2_p6, n_s2_p4, n_s2_p3;
    logic signed [btpc_pkg::PD_W-1:0]      n_s2_pdd;
    logic signed [btpc_pkg::T1D_W-1:0]     n_s3_t1d;
    logic signed [btpc_pkg::OFF_W-1:0]     n_s3_off;
    logic signed [btpc_pkg::SENS_W-1:0]    n_s3_sens;
    logic signed [btpc_pkg::FA_W-1:0]      n_s4_fa;
    logic signed [btpc_pkg::T_W-1:0]       n_s5_t;
    logic signed [btpc_pkg::OFF_W-1:0]     n_s5_off;
    logic signed [btpc_pkg::SENS_W-1:0]    n_s5_sens;
    logic [btpc_pkg::SLO_W-1:0]            n_s6_slo;
    logic signed [btpc_pkg::SENS_W-btpc_pkg::SLO_W-1:0] n_s6_shi;
    logic signed [btpc_pkg::T_W-1:0]       n_s6_t;
    logic                                  n_s6_tsat;
    logic signed [btpc_pkg::P_W-1:0]       n_s9_p;
    logic [btpc_pkg::PO_W-1:0]             n_s9_pc;
    logic                                  n_s9_psat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1 <= '0;
            r_c2 <= '0;
            r_c3 <= '0;
            r_c4 <= '0;
            r_c5 <= '0;
            r_c6 <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                btpc_pkg::CFG_SENS:       r_c1 <= i_cfg_data;
                btpc_pkg::CFG_OFFSET:     r_c2 <= i_cfg_data;
                btpc_pkg::CFG_SENS_TEMP:  r_c3 <= i_cfg_data;
                btpc_pkg::CFG_OFFSET_TMP: r_c4 <= i_cfg_data;
                btpc_pkg::CFG_REF_TEMP:   r_c5 <= i_cfg_data;
                btpc_pkg::CFG_TEMP_SLOPE: r_c6 <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // advance a stage when it is empty or the stage behind it advances
    always_comb begin
        w_adv[NS] = !r_vld[NS] || i_out_ready;
        for (int k = NS - 1; k >= 1; k--) begin
            w_adv[k] = !r_vld[k] || w_adv[k+1];
        end
    end

    assign o_in_ready  = w_adv[1];
    assign o_out_valid = r_vld[NS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[1]) begin
                r_vld[1] <= i_in_valid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (w_adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // datapath terms
    always_comb begin
        n_s1_d2 = i_raw_temperature & btpc_pkg::RAW_MASK;
        n_s1_d1 = i_raw_pressure & btpc_pkg::RAW_MASK;
        n_s1_dt = $signed({1'b0, n_s1_d2}) - $signed({1'b0, r_c5, 8'h00});

        n_s2_p6  = btpc_pkg::PM_W'(r_s1_dt) * btpc_pkg::PM_W'($signed({1'b0, r_c6}));
        n_s2_p4  = btpc_pkg::PM_W'(r_s1_dt) * btpc_pkg::PM_W'($signed({1'b0, r_c4}));
        n_s2_p3  = btpc_pkg::PM_W'(r_s1_dt) * btpc_pkg::PM_W'($signed({1'b0, r_c3}));
        n_s2_pdd = btpc_pkg::PD_W'(r_s1_dt) * btpc_pkg::PD_W'(r_s1_dt);

        n_s3_t1d  = $signed(r_s2_p6[40:23]);
        n_s3_off  = btpc_pkg::OFF_W'($signed({1'b0, r_c2, 16'h0000}))
                  + btpc_pkg::OFF_W'($signed(r_s2_p4[40:7]));
        n_s3_sens = btpc_pkg::SENS_W'($signed({1'b0, r_c1, 15'h0000}))
                  + btpc_pkg::SENS_W'($signed(r_s2_p3[40:8]));

        n_s4_fa = btpc_pkg::FA_W'(r_s3_t1d5) * btpc_pkg::FA_W'(r_s3_t1d);

        if (r_s4_low) begin
            n_s5_t    = r_s4_t1 - btpc_pkg::T_W'($signed({1'b0, r_s4_dd}));
            n_s5_off  = r_s4_off - btpc_pkg::OFF_W'($signed({1'b0, r_s4_fa[37:1]}));
            n_s5_sens = r_s4_sens - btpc_pkg::SENS_W'($signed({1'b0, r_s4_fa[37:2]}));
        end else begin
            n_s5_t    = r_s4_t1;
            n_s5_off  = r_s4_off;
            n_s5_sens = r_s4_sens;
        end

        n_s6_slo  = r_s5_sens[btpc_pkg::SLO_W-1:0];
        n_s6_shi  = r_s5_sens[btpc_pkg::SENS_W-1:btpc_pkg::SLO_W];
        n_s6_tsat = 1'b0;
        n_s6_t    = r_s5_t;
        if (r_s5_t < btpc_pkg::TEMP_MIN) begin
            n_s6_t    = btpc_pkg::TEMP_MIN;
            n_s6_tsat = 1'b1;
        end else if (r_s5_t > btpc_pkg::TEMP_MAX) begin
            n_s6_t    = btpc_pkg::TEMP_MAX;
            n_s6_tsat = 1'b1;
        end

        n_s9_p    = r_s8_q[btpc_pkg::Q_W-1:15];
        n_s9_psat = 1'b0;
        n_s9_pc   = btpc_pkg::PO_W'(n_s9_p);
        if (n_s9_p < btpc_pkg::PRES_MIN) begin
            n_s9_pc   = btpc_pkg::PO_W'(btpc_pkg::PRES_MIN);
            n_s9_psat = 1'b1;
        end else if (n_s9_p > btpc_pkg::PRES_MAX) begin
            n_s9_pc   = btpc_pkg::PO_W'(btpc_pkg::PRES_MAX);
            n_s9_psat = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= n_s1_d1;
        end
        if (w_adv[2]) begin
            r_s2_p6  <= n_s2_p6;
            r_s2_p4  <= n_s2_p4;
            r_s2_p3  <= n_s2_p3;
            r_s2_pdd <= n_s2_pdd;
            r_s2_d1  <= r_s1_d1;
        end
        if (w_adv[3]) begin
            r_s3_t1d  <= n_s3_t1d;
            r_s3_t1d5 <= btpc_pkg::T5_W'(n_s3_t1d) + (btpc_pkg::T5_W'(n_s3_t1d) <<< 2);
            r_s3_t1   <= btpc_pkg::TEMP_BASE + btpc_pkg::T_W'(n_s3_t1d);
            r_s3_dd   <= r_s2_pdd[48:31];
            r_s3_off  <= n_s3_off;
            r_s3_sens <= n_s3_sens;
            r_s3_low  <= n_s3_t1d[btpc_pkg::T1D_W-1];
            r_s3_d1   <= r_s2_d1;
        end
        if (w_adv[4]) begin
            r_s4_fa   <= n_s4_fa;
            r_s4_t1   <= r_s3_t1;
            r_s4_dd   <= r_s3_dd;
            r_s4_off  <= r_s3_off;
            r_s4_sens <= r_s3_sens;
            r_s4_low  <= r_s3_low;
            r_s4_d1   <= r_s3_d1;
        end
        if (w_adv[5]) begin
            r_s5_t    <= n_s5_t;
            r_s5_off  <= n_s5_off;
            r_s5_sens <= n_s5_sens;
            r_s5_low  <= r_s4_low;
            r_s5_d1   <= r_s4_d1;
        end
        if (w_adv[6]) begin
            r_s6_ppl  <= btpc_pkg::PPL_W'(r_s5_d1) * btpc_pkg::PPL_W'(n_s6_slo);
            r_s6_pph  <= btpc_pkg::PPH_W'($signed({1'b0, r_s5_d1}))
                       * btpc_pkg::PPH_W'(n_s6_shi);
            r_s6_off  <= r_s5_off;
            r_s6_t    <= n_s6_t;
            r_s6_tsat <= n_s6_tsat;
            r_s6_low  <= r_s5_low;
        end
        if (w_adv[7]) begin
            r_s7_prd  <= (btpc_pkg::PRD_W'(r_s6_pph) <<< btpc_pkg::SLO_W)
                       + btpc_pkg::PRD_W'($signed({1'b0, r_s6_ppl}));
            r_s7_off  <= r_s6_off;
            r_s7_t    <= r_s6_t;
            r_s7_tsat <= r_s6_tsat;
            r_s7_low  <= r_s6_low;
        end
        if (w_adv[8]) begin
            r_s8_q    <= btpc_pkg::Q_W'($signed(r_s7_prd[btpc_pkg::PRD_W-1:21]))
                       - btpc_pkg::Q_W'(r_s7_off);
            r_s8_t    <= r_s7_t;
            r_s8_tsat <= r_s7_tsat;
            r_s8_low  <= r_s7_low;
        end
        if (w_adv[9]) begin
            r_s9_t   <= r_s8_t[btpc_pkg::TO_W-1:0];
            r_s9_p   <= n_s9_pc;
            r_s9_low <= r_s8_low;
            r_s9_sat <= r_s8_tsat | n_s9_psat;
        end
    end

    assign o_temperature_centi = r_s9_t;
    assign o_pressure_pa       = r_s9_p;
    assign o_low_temp_applied  = r_s9_low;
    assign o_clamped           = r_s9_sat;

endmodule

@@ test/baro_temp_pressure_compensation_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_unit_test
// Self-checking bench for the barometer compensation pipeline.
// ----------------------------------------------------------------------------
// Drives raw temperature / pressure pairs through the valid/ready input and
// scores every compensated reading against an in-bench 64-bit integer model
// of the first- and second-order correction, including saturation and the
// low-temperature flag. A short table covers reset calibration, ignored
// register indexes, the 20 degree boundary, negative sensitivity and both
// saturation limits; several random calibration sets follow, with bursty
// gaps on the input and stalls on the output.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_unit_test;

    localparam int NUM_COEF        = 6;
    localparam int NUM_PHASES      = 7;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int QUIET_LIMIT     = 2000;

    localparam logic [btpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_LO = 3'd6;
    localparam logic [btpc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_HI = 3'd7;

    localparam logic [NUM_COEF-1:0][btpc_pkg::COEF_W-1:0] TYPICAL_CAL = {
        16'd28312, 16'd33464, 16'd23282, 16'd23317, 16'd36924, 16'd40127
    };

    typedef enum logic {ROW_PAIR, ROW_CFG} t_row_kind;
    typedef enum logic [1:0] {CAL_TYPICAL, CAL_CORNER, CAL_SPREAD} t_cal_style;

    typedef struct packed {
        logic signed [btpc_pkg::TO_W-1:0] temp;
        logic [btpc_pkg::PO_W-1:0]        pres;
        logic                             low;
        logic                             sat;
    } t_reading;

    typedef struct packed {
        logic [btpc_pkg::RAW_PORT_W-1:0] d2;
        logic [btpc_pkg::RAW_PORT_W-1:0] d1;
        t_reading                        want;
    } t_awaited;

    typedef struct packed {
        t_row_kind                       kind;
        logic [btpc_pkg::CFG_IDX_W-1:0]  idx;
        logic [btpc_pkg::COEF_W-1:0]     data;
        logic [btpc_pkg::RAW_PORT_W-1:0] d2;
        logic [btpc_pkg::RAW_PORT_W-1:0] d1;
        logic                            pin;
    } t_dir_row;

    // all calibration words zero: T stays at 20.00 degC, pressure floors at the limit
    localparam t_reading ZERO_CAL_READING = '{
        temp: 15'sd2000, pres: 17'd1000, low: 1'b0, sat: 1'b1
    };

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             i_cfg_valid = 1'b0;
    logic                             o_cfg_ready;
    logic [btpc_pkg::CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [btpc_pkg::COEF_W-1:0]      i_cfg_data = '0;
    logic                             i_in_valid = 1'b0;
    logic                             o_in_ready;
    logic [btpc_pkg::RAW_PORT_W-1:0]  i_raw_temperature = '0;
    logic [btpc_pkg::RAW_PORT_W-1:0]  i_raw_pressure = '0;
    logic                             o_out_valid;
    logic                             i_out_ready = 1'b0;
    logic signed [btpc_pkg::TO_W-1:0] o_temperature_centi;
    logic [btpc_pkg::PO_W-1:0]        o_pressure_pa;
    logic                             o_low_temp_applied;
    logic                             o_clamped;

    logic [NUM_COEF-1:0][btpc_pkg::COEF_W-1:0] cal_word = '0;
    t_awaited awaited_readings[$];
    logic     pin_now = 1'b0;

    int src_gap_pct = 0;
    int sink_stall_pct = 0;
    int beats_sent = 0;
    int results_seen = 0;
    int low_seen = 0;
    int clamp_seen = 0;
    int cfg_writes = 0;
    int settings = 1;
    int mismatches = 0;
    int quiet_cycles = 0;

    baro_temp_pressure_compensation_unit DUT (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_in_valid          (i_in_valid),
        .o_in_ready          (o_in_ready),
        .i_raw_temperature   (i_raw_temperature),
        .i_raw_pressure      (i_raw_pressure),
        .o_out_valid         (o_out_valid),
        .i_out_ready         (i_out_ready),
        .o_temperature_centi (o_temperature_centi),
        .o_pressure_pa       (o_pressure_pa),
        .o_low_temp_applied  (o_low_temp_applied),
        .o_clamped           (o_clamped)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_reading compensate_reading(
        input logic [btpc_pkg::RAW_PORT_W-1:0] raw_t,
        input logic [btpc_pkg::RAW_PORT_W-1:0] raw_p);
        longint d2, d1, c1, c2, c3, c4, c5, c6;
        longint dt, t1, t, off, sens, a, p;
        t_reading r;
        d2 = longint'(raw_t & btpc_pkg::RAW_MASK);
        d1 = longint'(raw_p & btpc_pkg::RAW_MASK);
        c1 = longint'(cal_word[btpc_pkg::CFG_SENS]);
        c2 = longint'(cal_word[btpc_pkg::CFG_OFFSET]);
        c3 = longint'(cal_word[btpc_pkg::CFG_SENS_TEMP]);
        c4 = longint'(cal_word[btpc_pkg::CFG_OFFSET_TMP]);
        c5 = longint'(cal_word[btpc_pkg::CFG_REF_TEMP]);
        c6 = longint'(cal_word[btpc_pkg::CFG_TEMP_SLOPE]);
        r.low = 1'b0;
        r.sat = 1'b0;
        dt = d2 - c5 * 256;
        t1 = btpc_pkg::TEMP_BASE + ((dt * c6) >>> 23);
        off = c2 * 65536 + ((c4 * dt) >>> 7);
        sens = c1 * 32768 + ((c3 * dt) >>> 8);
        t = t1;
        if (t1 < btpc_pkg::TEMP_BASE) begin
            a = (t1 - btpc_pkg::TEMP_BASE) * (t1 - btpc_pkg::TEMP_BASE);
            r.low = 1'b1;
            t = t1 - ((dt * dt) >>> 31);
            off = off - ((5 * a) >>> 1);
            sens = sens - ((5 * a) >>> 2);
        end
        p = (((d1 * sens) >>> 21) - off) >>> 15;
        if (t < btpc_pkg::TEMP_MIN) begin
            t = btpc_pkg::TEMP_MIN;
            r.sat = 1'b1;
        end
        if (t > btpc_pkg::TEMP_MAX) begin
            t = btpc_pkg::TEMP_MAX;
            r.sat = 1'b1;
        end
        if (p < btpc_pkg::PRES_MIN) begin
            p = btpc_pkg::PRES_MIN;
            r.sat = 1'b1;
        end
        if (p > btpc_pkg::PRES_MAX) begin
            p = btpc_pkg::PRES_MAX;
            r.sat = 1'b1;
        end
        r.temp = t[btpc_pkg::TO_W-1:0];
        r.pres = p[btpc_pkg::PO_W-1:0];
        return r;
    endfunction

    function automatic t_dir_row cfg_row(input logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                                         input logic [btpc_pkg::COEF_W-1:0] data);
        t_dir_row row;
        row = '0;
        row.kind = ROW_CFG;
        row.idx = idx;
        row.data = data;
        return row;
    endfunction

    function automatic t_dir_row pair_row(input logic [btpc_pkg::RAW_PORT_W-1:0] d2,
                                          input logic [btpc_pkg::RAW_PORT_W-1:0] d1,
                                          input logic pin);
        t_dir_row row;
        row = '0;
        row.kind = ROW_PAIR;
        row.d2 = d2;
        row.d1 = d1;
        row.pin = pin;
        return row;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $realtime, msg);
    endtask

    // leave valid high so back-to-back writes need no extra step
    task automatic write_coef(input logic [btpc_pkg::CFG_IDX_W-1:0] idx,
                              input logic [btpc_pkg::COEF_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic push_sample(input logic [btpc_pkg::RAW_PORT_W-1:0] d2,
                               input logic [btpc_pkg::RAW_PORT_W-1:0] d1,
                               input logic pin);
        if (src_gap_pct != 0 && $urandom_range(0, 99) < src_gap_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_raw_temperature <= d2;
        i_raw_pressure <= d1;
        pin_now <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        beats_sent++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (results_seen != beats_sent) @(posedge i_clk);
    endtask

    // output stall bursts
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_reading got;
        t_awaited exp_entry;
        logic     any_beat;
        any_beat = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index < NUM_COEF)
                    cal_word[i_cfg_index] = i_cfg_data;
                cfg_writes++;
                any_beat = 1'b1;
            end
            if (i_in_valid && o_in_ready) begin
                exp_entry.d2 = i_raw_temperature;
                exp_entry.d1 = i_raw_pressure;
                exp_entry.want = pin_now ? ZERO_CAL_READING
                                         : compensate_reading(i_raw_temperature, i_raw_pressure);
                awaited_readings.push_back(exp_entry);
                any_beat = 1'b1;
            end
            if (o_out_valid && i_out_ready) begin
                got.temp = o_temperature_centi;
                got.pres = o_pressure_pa;
                got.low = o_low_temp_applied;
                got.sat = o_clamped;
                results_seen++;
                if (o_low_temp_applied)
                    low_seen++;
                if (o_clamped)
                    clamp_seen++;
                any_beat = 1'b1;
                if (awaited_readings.size() == 0) begin
                    flag_mismatch($sformatf("unexpected reading T=%0d P=%0d",
                                            got.temp, got.pres));
                end else begin
                    exp_entry = awaited_readings.pop_front();
                    if (got.temp !== exp_entry.want.temp)
                        flag_mismatch($sformatf("temperature_centi %0d, want %0d (D2=%h D1=%h)",
                            got.temp, exp_entry.want.temp, exp_entry.d2, exp_entry.d1));
                    if (got.pres !== exp_entry.want.pres)
                        flag_mismatch($sformatf("pressure_pa %0d, want %0d (D2=%h D1=%h)",
                            got.pres, exp_entry.want.pres, exp_entry.d2, exp_entry.d1));
                    if (got.low !== exp_entry.want.low)
                        flag_mismatch($sformatf("low_temp_applied %b, want %b (D2=%h D1=%h)",
                            got.low, exp_entry.want.low, exp_entry.d2, exp_entry.d1));
                    if (got.sat !== exp_entry.want.sat)
                        flag_mismatch($sformatf("clamped %b, want %b (D2=%h D1=%h)",
                            got.sat, exp_entry.want.sat, exp_entry.d2, exp_entry.d1));
                end
            end
        end
        if (any_beat)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("[baro_temp_pressure_compensation_unit] ERROR");
        $finish;
    end

    initial begin
        t_dir_row                        steps[$];
        t_row_kind                       prev_kind;
        t_cal_style                      style;
        logic [btpc_pkg::RAW_PORT_W-1:0] raw_t;
        logic [btpc_pkg::RAW_PORT_W-1:0] raw_p;
        int                              spread;
        int                              d2_center;
        int                              w;
        int                              phase;
        int                              n;
        int                              i;

        // reset calibration, then ignored indexes
        steps.push_back(pair_row(24'h000000, 24'h000000, 1'b1));
        steps.push_back(pair_row(24'hFFFFFF, 24'hFFFFFF, 1'b1));
        steps.push_back(pair_row(24'hAAAAAA, 24'h555555, 1'b1));
        steps.push_back(pair_row(24'h555555, 24'hAAAAAA, 1'b1));
        steps.push_back(cfg_row(CFG_UNUSED_LO, 16'hFFFF));
        steps.push_back(cfg_row(CFG_UNUSED_HI, 16'hFFFF));
        steps.push_back(pair_row(24'h123456, 24'h654321, 1'b1));
        // typical part: room temperature, below 20 degC, both saturation ends
        steps.push_back(cfg_row(btpc_pkg::CFG_SENS, TYPICAL_CAL[btpc_pkg::CFG_SENS]));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET, TYPICAL_CAL[btpc_pkg::CFG_OFFSET]));
        steps.push_back(cfg_row(btpc_pkg::CFG_SENS_TEMP,
                                TYPICAL_CAL[btpc_pkg::CFG_SENS_TEMP]));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET_TMP,
                                TYPICAL_CAL[btpc_pkg::CFG_OFFSET_TMP]));
        steps.push_back(cfg_row(btpc_pkg::CFG_REF_TEMP,
                                TYPICAL_CAL[btpc_pkg::CFG_REF_TEMP]));
        steps.push_back(cfg_row(btpc_pkg::CFG_TEMP_SLOPE,
                                TYPICAL_CAL[btpc_pkg::CFG_TEMP_SLOPE]));
        steps.push_back(pair_row(24'd8569150, 24'd9085466, 1'b0));
        steps.push_back(pair_row(24'd8466784, 24'd9085466, 1'b0));
        steps.push_back(pair_row(24'h000000, 24'h000000, 1'b0));
        steps.push_back(pair_row(24'hFFFFFF, 24'hFFFFFF, 1'b0));
        // all words at max: dT of zero and minus one straddle the 20 degC test
        steps.push_back(cfg_row(btpc_pkg::CFG_SENS, 16'hFFFF));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET, 16'hFFFF));
        steps.push_back(cfg_row(btpc_pkg::CFG_SENS_TEMP, 16'hFFFF));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET_TMP, 16'hFFFF));
        steps.push_back(cfg_row(btpc_pkg::CFG_REF_TEMP, 16'hFFFF));
        steps.push_back(cfg_row(btpc_pkg::CFG_TEMP_SLOPE, 16'hFFFF));
        steps.push_back(pair_row(24'h000000, 24'hFFFFFF, 1'b0));
        steps.push_back(pair_row(24'hFFFFFF, 24'h000000, 1'b0));
        steps.push_back(pair_row(24'hFFFF00, 24'h800000, 1'b0));
        steps.push_back(pair_row(24'hFFFEFF, 24'h800000, 1'b0));
        // negative sensitivity: no base terms, steep slope, coldest input
        steps.push_back(cfg_row(btpc_pkg::CFG_SENS, 16'h0000));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET, 16'h0000));
        steps.push_back(cfg_row(btpc_pkg::CFG_OFFSET_TMP, 16'h0000));
        steps.push_back(pair_row(24'h000000, 24'hFFFFFF, 1'b0));
        steps.push_back(pair_row(24'h000000, 24'h000000, 1'b0));

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        src_gap_pct = 15;
        sink_stall_pct = 15;

        prev_kind = ROW_PAIR;
        foreach (steps[k]) begin
            if (steps[k].kind == ROW_CFG) begin
                if (prev_kind == ROW_PAIR)
                    drain_results();
                if (prev_kind == ROW_PAIR)
                    settings++;
                write_coef(steps[k].idx, steps[k].data);
            end else begin
                if (prev_kind == ROW_CFG)
                    i_cfg_valid <= 1'b0;
                push_sample(steps[k].d2, steps[k].d1, steps[k].pin);
            end
            prev_kind = steps[k].kind;
        end

        for (phase = 0; phase < NUM_PHASES; phase++) begin
            drain_results();
            case (phase)
                0, NUM_PHASES - 1: style = CAL_TYPICAL;
                1: style = CAL_CORNER;
                2: style = CAL_SPREAD;
                default: style = t_cal_style'($urandom_range(0, 2));
            endcase
            if (phase == NUM_PHASES - 1) begin
                src_gap_pct = 0;
                sink_stall_pct = 0;
            end else begin
                src_gap_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
                sink_stall_pct = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 40);
            end
            for (i = 0; i < NUM_COEF; i++) begin
                case (style)
                    CAL_TYPICAL: w = int'(TYPICAL_CAL[i]) + int'($urandom_range(0, 8000)) - 4000;
                    CAL_CORNER: w = ($urandom_range(0, 1) == 0) ? 0 : 65535;
                    default: w = $urandom_range(0, 65535);
                endcase
                if (w < 0)
                    w = 0;
                else if (w > 65535)
                    w = 65535;
                write_coef(btpc_pkg::CFG_IDX_W'(i), btpc_pkg::COEF_W'(w));
            end
            if ($urandom_range(0, 2) == 0)
                write_coef(($urandom_range(0, 1) == 0) ? CFG_UNUSED_LO : CFG_UNUSED_HI,
                           btpc_pkg::COEF_W'($urandom));
            i_cfg_valid <= 1'b0;
            settings++;

            for (n = 0; n < ITEMS_PER_PHASE; n++) begin
                if ($urandom_range(0, 3) != 0) begin
                    spread = 1 << $urandom_range(6, 22);
                    d2_center = int'(cal_word[btpc_pkg::CFG_REF_TEMP]) * 256
                              + int'($urandom_range(0, 2 * spread)) - spread;
                    if (d2_center < 0)
                        d2_center = 0;
                    else if (d2_center > 16777215)
                        d2_center = 16777215;
                    raw_t = btpc_pkg::RAW_PORT_W'(d2_center);
                    raw_p = btpc_pkg::RAW_PORT_W'(9000000 + int'($urandom_range(0, 6000000))
                                                  - 3000000);
                end else begin
                    raw_t = btpc_pkg::RAW_PORT_W'($urandom);
                    raw_p = btpc_pkg::RAW_PORT_W'($urandom);
                    case ($urandom_range(0, 7))
                        0: raw_t = '0;
                        1: raw_t = '1;
                        2: raw_p = '0;
                        3: raw_p = '1;
                        default: ;
                    endcase
                end
                push_sample(raw_t, raw_p, 1'b0);
            end
        end

        drain_results();
        repeat (24) @(posedge i_clk);
        if (awaited_readings.size() != 0)
            flag_mismatch($sformatf("%0d readings never came out", awaited_readings.size()));
        $display("Sent %0d conversion pairs under %0d calibration sets (%0d register writes).",
                 beats_sent, settings, cfg_writes);
        $display("Scored %0d readings: %0d with low-temperature correction, %0d saturated.",
                 results_seen, low_seen, clamp_seen);
        if (mismatches == 0)
            $display("[baro_temp_pressure_compensation_unit] OK");
        else
            $display("[baro_temp_pressure_compensation_unit] ERROR");
        $finish;
    end

endmodule
